// File: sv/fcbd_pkg.sv
// ----------------------------------------------------------------------------
// fcbd_pkg
// Character classes and constants shared by the fenced code block detector.
// ----------------------------------------------------------------------------
package fcbd_pkg;

	localparam logic [15:0] CH_TICK  = 16'h0060;
	localparam logic [15:0] CH_SPACE = 16'h0020;
	localparam logic [15:0] CH_TAB   = 16'h0009;
	localparam logic [15:0] CH_CR    = 16'h000D;
	localparam logic [15:0] CH_LF    = 16'h000A;

	localparam logic [1:0] INDENT_LIMIT = 2'd3;
	localparam int unsigned MIN_FENCE   = 3;

	typedef struct packed {
		logic tick;
		logic space;
		logic tab;
		logic cr;
		logic lf;
	} char_class_t;

	typedef struct packed {
		logic       keep_char;
		logic [1:0] block_state;
	} fcbd_result_t;

endpackage

// File: sv/fcbd_class.sv
// ----------------------------------------------------------------------------
// fcbd_class
// Decodes a UTF-16 code unit into the character classes the detector uses.
// ----------------------------------------------------------------------------
module fcbd_class (
	input  logic [15:0]          char_code,
	output fcbd_pkg::char_class_t cls
);
	import fcbd_pkg::*;

	always_comb begin
		cls.tick  = (char_code == CH_TICK);
		cls.space = (char_code == CH_SPACE);
		cls.tab   = (char_code == CH_TAB);
		cls.cr    = (char_code == CH_CR);
		cls.lf    = (char_code == CH_LF);
	end

endmodule

// File: sv/fcbd_fsm.sv
// ----------------------------------------------------------------------------
// fcbd_fsm
// Fence tracking state and per-character next-state logic with result register.
// ----------------------------------------------------------------------------
module fcbd_fsm #(
	parameter int unsigned MAX_RUN = 255
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  fcbd_pkg::char_class_t  cls,
	input  logic                   sol,
	input  logic                   include_fences,
	output fcbd_pkg::fcbd_result_t result
);
	import fcbd_pkg::*;

	localparam int unsigned RUN_W = $clog2(MAX_RUN + 1);
	localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_RUN);
	localparam logic [RUN_W-1:0] RUN_MIN = RUN_W'(MIN_FENCE);
	localparam logic [RUN_W-1:0] RUN_ONE = RUN_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_TRY  = 2'd1,
		ST_IN   = 2'd2
	} mode_t;

	mode_t            mode_q, mode_d;
	logic [1:0]       open_indent_q, open_indent_d;
	logic [RUN_W-1:0] open_run_q, open_run_d;
	logic [RUN_W-1:0] fence_len_q, fence_len_d;
	logic             on_open_q, on_open_d;
	logic             close_cand_q, close_cand_d;
	logic [1:0]       close_indent_q, close_indent_d;
	logic [RUN_W-1:0] close_run_q, close_run_d;
	logic             trail_only_q, trail_only_d;
	logic             keep_d;

	logic             cc, to;
	logic [1:0]       ci;
	logic [RUN_W-1:0] cr_run, sat_open, sat_close;

	fcbd_result_t result_s2;

	assign sat_open = (open_run_q < RUN_MAX) ? open_run_q + RUN_ONE : RUN_MAX;

	always_comb begin
		mode_d         = mode_q;
		open_indent_d  = open_indent_q;
		open_run_d     = open_run_q;
		fence_len_d    = fence_len_q;
		on_open_d      = on_open_q;
		close_cand_d   = close_cand_q;
		close_indent_d = close_indent_q;
		close_run_d    = close_run_q;
		trail_only_d   = trail_only_q;
		keep_d         = 1'b1;

		cc     = sol ? 1'b1 : close_cand_q;
		ci     = sol ? 2'd0 : close_indent_q;
		cr_run = sol ? '0 : close_run_q;
		to     = sol ? 1'b1 : trail_only_q;
		sat_close = (cr_run < RUN_MAX) ? cr_run + RUN_ONE : RUN_MAX;

		unique case (mode_q)
			ST_TRY: begin
				if (open_run_q == '0) begin
					if (cls.space && open_indent_q < INDENT_LIMIT) begin
						open_indent_d = open_indent_q + 2'd1;
						keep_d        = include_fences;
					end else if (cls.tick) begin
						open_run_d = RUN_ONE;
						keep_d     = include_fences;
					end else begin
						mode_d        = ST_IDLE;
						open_indent_d = 2'd0;
						open_run_d    = '0;
						fence_len_d   = '0;
						on_open_d     = 1'b0;
						close_cand_d  = 1'b0;
						close_indent_d = 2'd0;
						close_run_d   = '0;
						trail_only_d  = 1'b1;
					end
				end else if (cls.tick) begin
					open_run_d = sat_open;
					keep_d     = include_fences;
					if (sat_open >= RUN_MIN) begin
						fence_len_d  = sat_open;
						on_open_d    = 1'b1;
						close_cand_d = 1'b0;
						mode_d       = ST_IN;
					end
				end else begin
					mode_d        = ST_IDLE;
					open_indent_d = 2'd0;
					open_run_d    = '0;
					fence_len_d   = '0;
					on_open_d     = 1'b0;
					close_cand_d  = 1'b0;
					close_indent_d = 2'd0;
					close_run_d   = '0;
					trail_only_d  = 1'b1;
				end
			end
			ST_IN: begin
				if (on_open_q) begin
					keep_d = include_fences;
					if (cls.lf) begin
						on_open_d    = 1'b0;
						close_cand_d = 1'b0;
					end
				end else begin
					close_cand_d   = cc;
					close_indent_d = ci;
					close_run_d    = cr_run;
					trail_only_d   = to;
					if (!cc) begin
						keep_d = 1'b1;
					end else if (cls.lf) begin
						close_cand_d   = 1'b0;
						close_indent_d = 2'd0;
						close_run_d    = '0;
						trail_only_d   = 1'b1;
						if (cr_run >= fence_len_q && cr_run >= RUN_MIN && to) begin
							mode_d        = ST_IDLE;
							open_indent_d = 2'd0;
							open_run_d    = '0;
							fence_len_d   = '0;
							on_open_d     = 1'b0;
							keep_d        = include_fences;
						end
					end else if (cr_run == '0 && cls.space && ci < INDENT_LIMIT) begin
						close_indent_d = ci + 2'd1;
						keep_d         = include_fences;
					end else if (cls.tick) begin
						close_run_d = sat_close;
						keep_d      = include_fences;
					end else if (cr_run != '0 && (cls.space || cls.tab || cls.cr)) begin
						keep_d = include_fences;
					end else begin
						close_cand_d = 1'b0;
						trail_only_d = 1'b0;
					end
				end
			end
			default: begin
				if (sol && cls.space) begin
					open_indent_d = 2'd1;
					mode_d        = ST_TRY;
					keep_d        = include_fences;
				end else if (sol && cls.tick) begin
					open_run_d = RUN_ONE;
					mode_d     = ST_TRY;
					keep_d     = include_fences;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= ST_IDLE;
			open_indent_q  <= 2'd0;
			open_run_q     <= '0;
			fence_len_q    <= '0;
			on_open_q      <= 1'b0;
			close_cand_q   <= 1'b0;
			close_indent_q <= 2'd0;
			close_run_q    <= '0;
			trail_only_q   <= 1'b1;
		end else if (step) begin
			mode_q         <= mode_d;
			open_indent_q  <= open_indent_d;
			open_run_q     <= open_run_d;
			fence_len_q    <= fence_len_d;
			on_open_q      <= on_open_d;
			close_cand_q   <= close_cand_d;
			close_indent_q <= close_indent_d;
			close_run_q    <= close_run_d;
			trail_only_q   <= trail_only_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2.keep_char   <= keep_d;
			result_s2.block_state <= mode_d;
		end
	end

	assign result = result_s2;

endmodule

// File: sv/fenced_code_block_detector.sv
// ----------------------------------------------------------------------------
// fenced_code_block_detector
// Tracks backtick fenced code blocks over a UTF-16 character stream.
// ----------------------------------------------------------------------------
//  channel  | dir | signals                        | content
//  ---------+-----+--------------------------------+---------------------------
//  s_*      | in  | s_tvalid s_tready s_tdata s_tuser | char_code, at_line_start
//  m_*      | out | m_tvalid m_tready m_tdata      | keep_char, block_state
//  cfg_*    | in  | cfg_we cfg_wdata               | include_fences
//
// One request per cycle sustained while m_tready is high; an accepted request
// passes the input register, then the state update into the result register.
// The state loop closes through the next-state logic.
// arst_n clears the state, the pipeline valids and include_fences.
// A stalled result holds in its register while one more request waits
// in the input register.
module fenced_code_block_detector #(
	parameter int unsigned MAX_RUN = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] char_code
	input  logic        s_tuser,   // [0] at_line_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] keep_char, [2:1] block_state, [7:3] zero
	input  logic        cfg_we,
	input  logic        cfg_wdata
);
	import fcbd_pkg::*;

	char_class_t  cls_in, cls_s1;
	logic         sol_s1;
	logic         v_s1, v_s2;
	logic         step;
	logic         include_fences_q;
	fcbd_result_t result;

	fcbd_class u_class (
		.char_code (s_tdata),
		.cls       (cls_in)
	);

	assign step     = v_s1 && (!v_s2 || m_tready);
	assign s_tready = !v_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1             <= 1'b0;
			v_s2             <= 1'b0;
			include_fences_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				v_s1 <= 1'b1;
			else if (step)
				v_s1 <= 1'b0;
			if (step)
				v_s2 <= 1'b1;
			else if (m_tready)
				v_s2 <= 1'b0;
			if (cfg_we)
				include_fences_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cls_s1 <= cls_in;
			sol_s1 <= s_tuser;
		end
	end

	fcbd_fsm #(
		.MAX_RUN (MAX_RUN)
	) u_fsm (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.cls            (cls_s1),
		.sol            (sol_s1),
		.include_fences (include_fences_q),
		.result         (result)
	);

	assign m_tvalid = v_s2;
	assign m_tdata  = {5'd0, result.block_state, result.keep_char};

endmodule

// File: sv/fcbd_checker.sv
// ----------------------------------------------------------------------------
// fcbd_checker
// Port-level checks for the fenced code block detector.
// ----------------------------------------------------------------------------
module fcbd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        cfg_we,
	input logic        cfg_wdata
);
	logic [1:0] pending_q;
	logic       incl_q;
	logic       s_fire, m_fire;

	assign s_fire = s_tvalid && s_tready;
	assign m_fire = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
			incl_q    <= 1'b0;
		end else begin
			pending_q <= pending_q + {1'b0, s_fire} - {1'b0, m_fire};
			if (cfg_we)
				incl_q <= cfg_wdata;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 2'd0)
		else $error("result without pending request");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two requests in flight");

	a_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:1] != 2'd3 && m_tdata[7:3] == 5'd0)
		else $error("bad result encoding");

	a_try_keep: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:1] == 2'd1 |-> m_tdata[0] == incl_q)
		else $error("opener character keep mismatch");

endmodule

bind fenced_code_block_detector fcbd_checker u_fcbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_we    (cfg_we),
	.cfg_wdata (cfg_wdata)
);

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fenced code block detector. Character requests
// come from directed cases, long backtick runs, an output stall and random
// Markdown-like lines. A behavioral tracker predicts keep_char and
// block_state per accepted request. Results are checked in order.
// ----------------------------------------------------------------------------
module tb;
	import fcbd_pkg::*;

	localparam int unsigned RUN_CAP  = 255;
	localparam int unsigned HOLD_LEN = 64;

	typedef enum logic [1:0] {
		FM_IDLE = 2'd0,
		FM_TRY  = 2'd1,
		FM_BODY = 2'd2
	} fence_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;

	fenced_code_block_detector #(.MAX_RUN(RUN_CAP)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2ms;
		$display("TB_ERROR");
		$finish;
	end

	// tracker state
	fence_mode_t fmode = FM_IDLE;
	logic [1:0]  open_indent = '0;
	logic [7:0]  open_run = '0;
	logic [7:0]  fence_len = '0;
	logic        on_open_line = 1'b0;
	logic        close_cand = 1'b0;
	logic [1:0]  close_indent = '0;
	logic [7:0]  close_run = '0;
	logic        trailing_only = 1'b1;
	logic        incl_fences = 1'b0;

	fcbd_result_t keep_q[$];
	fcbd_result_t want_r;
	int          n_bad = 0;
	int          sent_n = 0;
	bit          idle_on = 1'b1;
	bit          line_fresh = 1'b1;
	logic [7:0]  hold_req = '0;
	logic [7:0]  hold_ack = '0;
	int unsigned hold_left = 0;

	function automatic logic [7:0] run_inc(input logic [7:0] v);
		return (v < RUN_CAP) ? v + 8'd1 : 8'(RUN_CAP);
	endfunction

	function automatic void clear_fence();
		fmode = FM_IDLE;
		open_indent = '0;
		open_run = '0;
		fence_len = '0;
		on_open_line = 1'b0;
		close_cand = 1'b0;
		close_indent = '0;
		close_run = '0;
		trailing_only = 1'b1;
	endfunction

	function automatic fcbd_result_t track_char(input logic [15:0] c, input logic sol);
		fcbd_result_t r;
		logic keep;
		logic closes;
		keep = 1'b1;
		case (fmode)
			FM_BODY: begin
				if (on_open_line) begin
					if (c == CH_LF) begin
						on_open_line = 1'b0;
						close_cand = 1'b0;
					end
					keep = incl_fences;
				end else begin
					if (sol) begin
						close_cand = 1'b1;
						close_indent = '0;
						close_run = '0;
						trailing_only = 1'b1;
					end
					if (!close_cand) begin
						keep = 1'b1;
					end else if (c == CH_LF) begin
						closes = (close_run >= fence_len) && (close_run >= MIN_FENCE)
							&& trailing_only;
						close_cand = 1'b0;
						close_indent = '0;
						close_run = '0;
						trailing_only = 1'b1;
						if (closes) begin
							clear_fence();
							keep = incl_fences;
						end
					end else if (close_run == 0 && c == CH_SPACE
							&& close_indent < INDENT_LIMIT) begin
						close_indent = close_indent + 2'd1;
						keep = incl_fences;
					end else if (c == CH_TICK) begin
						close_run = run_inc(close_run);
						keep = incl_fences;
					end else if (close_run != 0
							&& (c == CH_SPACE || c == CH_TAB || c == CH_CR)) begin
						keep = incl_fences;
					end else begin
						close_cand = 1'b0;
						trailing_only = 1'b0;
					end
				end
			end
			FM_TRY: begin
				if (open_run == 0) begin
					if (c == CH_SPACE && open_indent < INDENT_LIMIT) begin
						open_indent = open_indent + 2'd1;
						keep = incl_fences;
					end else if (c == CH_TICK) begin
						open_run = 8'd1;
						keep = incl_fences;
					end else begin
						clear_fence();
					end
				end else if (c == CH_TICK) begin
					open_run = run_inc(open_run);
					if (open_run >= MIN_FENCE) begin
						fence_len = open_run;
						on_open_line = 1'b1;
						close_cand = 1'b0;
						fmode = FM_BODY;
					end
					keep = incl_fences;
				end else begin
					clear_fence();
				end
			end
			default: begin
				if (sol && c == CH_SPACE) begin
					open_indent = 2'd1;
					fmode = FM_TRY;
					keep = incl_fences;
				end else if (sol && c == CH_TICK) begin
					open_run = 8'd1;
					fmode = FM_TRY;
					keep = incl_fences;
				end
			end
		endcase
		r.keep_char = keep;
		r.block_state = fmode;
		return r;
	endfunction

	// result checker and output-side flow control
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (keep_q.size() == 0) begin
				$error("result with no request pending: m_tdata=%h", m_tdata);
				n_bad++;
			end else begin
				want_r = keep_q.pop_front();
				if (m_tdata[0] !== want_r.keep_char) begin
					$error("keep_char: expected %0d, got %0d", want_r.keep_char, m_tdata[0]);
					n_bad++;
				end
				if (m_tdata[2:1] !== want_r.block_state) begin
					$error("block_state: expected %0d, got %0d",
						want_r.block_state, m_tdata[2:1]);
					n_bad++;
				end
				if (m_tdata[7:3] !== 5'd0) begin
					$error("pad: expected 0, got %0h", m_tdata[7:3]);
					n_bad++;
				end
			end
		end
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_LEN;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(idle_on && $urandom_range(0, 99) < 19);
		end
	end

	task automatic send_char(input logic [15:0] c, input logic sol);
		while (idle_on && $urandom_range(0, 99) < 19) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tuser <= sol;
		do @(posedge clk); while (!s_tready);
		keep_q.push_back(track_char(c, sol));
		sent_n++;
	endtask

	task automatic emit(input logic [15:0] c);
		send_char(c, line_fresh);
		line_fresh = (c == CH_LF);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (keep_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_include(input logic v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		incl_fences = v;
	endtask

	function automatic logic [15:0] rand_char();
		case ($urandom_range(0, 9))
			0: return CH_TICK;
			1: return CH_SPACE;
			2: return CH_TAB;
			3: return CH_CR;
			4: return CH_LF;
			5, 6: return 16'($urandom_range(16'h21, 16'h7e));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic random_line();
		int kind;
		int n;
		kind = $urandom_range(0, 99);
		if (kind < 22) begin
			// opener-shaped line
			n = ($urandom_range(0, 9) == 0) ? 4 : $urandom_range(0, 3);
			repeat (n) emit(CH_SPACE);
			repeat ($urandom_range(2, 5)) emit(CH_TICK);
			repeat ($urandom_range(0, 6)) emit(rand_char());
			emit(CH_LF);
		end else if (kind < 48) begin
			// closer-shaped line
			n = ($urandom_range(0, 9) == 0) ? 4 : $urandom_range(0, 3);
			repeat (n) emit(CH_SPACE);
			repeat ($urandom_range(2, 6)) emit(CH_TICK);
			repeat ($urandom_range(0, 4)) begin
				case ($urandom_range(0, 9))
					0: emit(CH_TICK);
					1: emit(rand_char());
					2, 3: emit(CH_TAB);
					4: emit(CH_CR);
					default: emit(CH_SPACE);
				endcase
			end
			emit(CH_LF);
		end else if (kind < 88) begin
			repeat ($urandom_range(0, 12)) emit(rand_char());
			emit(CH_LF);
		end else begin
			repeat ($urandom_range(1, 8))
				send_char(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
			line_fresh = 1'($urandom_range(0, 1));
		end
	endtask

	task automatic test_directed();
		logic [16:0] seq [20];
		seq = '{
			{1'b1, 16'hFFFF}, {1'b0, 16'h0000},
			{1'b1, CH_SPACE}, {1'b1, CH_TICK}, {1'b0, CH_TICK}, {1'b0, CH_TICK},
			{1'b0, 16'h0078}, {1'b0, CH_LF},
			{1'b1, CH_SPACE}, {1'b0, CH_TICK}, {1'b0, CH_TICK}, {1'b0, CH_TICK},
			{1'b0, CH_SPACE}, {1'b0, CH_TICK}, {1'b0, CH_TAB}, {1'b0, CH_CR},
			{1'b0, CH_LF},
			{1'b1, CH_SPACE}, {1'b0, 16'hFFFF}, {1'b0, CH_TICK}
		};
		set_include(1'b1);
		set_include(1'b0);
		foreach (seq[i]) send_char(seq[i][15:0], seq[i][16]);
		send_char(CH_LF, 1'b0);
		line_fresh = 1'b1;
		drain();
	endtask

	task automatic test_run_saturation();
		set_include(1'b1);
		repeat (3) emit(CH_TICK);
		emit(CH_LF);
		repeat (300) emit(CH_TICK);
		emit(CH_SPACE);
		emit(CH_LF);
		drain();
	endtask

	task automatic test_output_stall();
		int start_n;
		set_include(1'b0);
		idle_on = 1'b0;
		hold_req <= hold_req + 8'd1;
		start_n = sent_n;
		while (sent_n - start_n < 100) random_line();
		idle_on = 1'b1;
		drain();
	endtask

	task automatic test_random_text(input logic incl, input int n_items, input bit idling);
		int start_n;
		set_include(incl);
		idle_on = idling;
		start_n = sent_n;
		while (sent_n - start_n < n_items) random_line();
		drain();
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_run_saturation();
		test_output_stall();
		test_random_text(1'b0, 350, 1'b1);
		test_random_text(1'b1, 350, 1'b1);
		test_random_text(1'b1, 150, 1'b0);
		test_random_text(1'b0, 350, 1'b1);
		test_random_text(1'b1, 350, 1'b1);
		repeat (10) @(posedge clk);
		if (n_bad == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
